[design/cle_pkg.sv]
`default_nettype none

package cle_pkg;

  // Line store geometry.
  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

  // Editing keys.
  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
  localparam logic [7:0] KEY_KILL      = 8'h15;
  localparam logic [7:0] KEY_EOF       = 8'h04;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SHOW  = 3'b100
  } cle_state_t;

endpackage

`default_nettype wire

[design/console_line_editor_unit.sv]
`default_nettype none

// Console line editor. Takes one keyboard byte per request and returns
// completed lines, one byte per output request, with last_of_line on the
// final byte and empty_line on the single result of a line ended by
// control-D with nothing in it. With raw_mode set, each byte comes back at
// once as a one-byte line. In cooked mode, backspace, control-U and bytes
// that do not end a line give no result. A byte that ends a line (newline,
// control-D, or the byte that fills the 64-entry store) starts the readout
// sequencer: a fetch state reads the first byte from the line memory, then
// one byte per cycle comes from its single registered read port while the
// output is not stalled. Input is stalled during readout. The line memory
// needs no clearing after reset.
module console_line_editor_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_line,
  output logic            empty_line
);

  import cle_pkg::*;

  cle_state_t       state, state_next;
  logic             raw_mode;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] line_len, line_len_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             direct, direct_next;
  logic             out_empty, out_empty_next;
  logic [7:0]       out_data;
  logic [7:0]       line_mem [LINE_DEPTH];

  logic             in_acc, out_acc;
  logic             mem_we, mem_re, load_direct;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]       direct_byte;
  logic [CNT_W-1:0] fill_inc, len_end;
  logic             is_store, ends_line, last_now;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_SHOW);

  // The result byte comes straight from the output register; last_of_line is decoded from the control registers.
  assign last_now     = direct || (rd_idx == line_len);
  assign out_byte     = out_data;
  assign last_of_line = last_now;
  assign empty_line   = out_empty;

  // Editing decode for a cooked byte.
  assign is_store  = (in_byte != KEY_BACKSPACE) && (in_byte != KEY_KILL);
  assign fill_inc  = fill + CNT_W'(1);
  assign ends_line = is_store && ((in_byte == KEY_NEWLINE) || (in_byte == KEY_EOF) ||
                                  (fill_inc == CNT_W'(LINE_DEPTH)));
  assign len_end   = (in_byte == KEY_EOF) ? fill : fill_inc;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
    end else if (cfg_write) begin
      raw_mode <= cfg_data;
    end
  end

  // Sequencer: editing or raw pass-through in idle, then readout of an ended line or raw byte.
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    line_len_next  = line_len;
    rd_idx_next    = rd_idx;
    direct_next    = direct;
    out_empty_next = out_empty;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = rd_idx[ADDR_W-1:0];
    load_direct    = 1'b0;
    direct_byte    = in_byte;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (raw_mode) begin
            load_direct    = 1'b1;
            direct_next    = 1'b1;
            out_empty_next = 1'b0;
            state_next     = S_SHOW;
          end else if (in_byte == KEY_BACKSPACE) begin
            if (fill != '0) begin
              fill_next = fill - CNT_W'(1);
            end
          end else if (in_byte == KEY_KILL) begin
            fill_next = '0;
          end else begin
            mem_we    = 1'b1;
            fill_next = fill_inc;
            if (ends_line) begin
              fill_next = '0;
              if (len_end == '0) begin
                load_direct    = 1'b1;
                direct_byte    = 8'h00;
                direct_next    = 1'b1;
                out_empty_next = 1'b1;
                state_next     = S_SHOW;
              end else begin
                line_len_next  = len_end;
                rd_idx_next    = '0;
                direct_next    = 1'b0;
                out_empty_next = 1'b0;
                state_next     = S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        mem_re      = 1'b1;
        rd_idx_next = rd_idx + CNT_W'(1);
        state_next  = S_SHOW;
      end
      S_SHOW: begin
        if (out_acc) begin
          if (last_now) begin
            state_next = S_IDLE;
          end else begin
            mem_re      = 1'b1;
            rd_idx_next = rd_idx + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      line_len  <= '0;
      rd_idx    <= '0;
      direct    <= 1'b0;
      out_empty <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      line_len  <= line_len_next;
      rd_idx    <= rd_idx_next;
      direct    <= direct_next;
      out_empty <= out_empty_next;
    end
  end

  // Line memory with registered read port, which is also the output register.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[fill[ADDR_W-1:0]] <= in_byte;
    end
    if (mem_re) begin
      out_data <= line_mem[mem_raddr];
    end else if (load_direct) begin
      out_data <= direct_byte;
    end
  end

  // An empty-line result is a lone, final, zero byte.
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_line) |-> (last_of_line && out_byte == 8'h00))
    else $error("empty-line result is malformed");

  // The held line never exceeds the store.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill < CNT_W'(LINE_DEPTH)))
    else $error("fill count out of range");

  // Readout of a stored line never runs past its length.
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !direct) |-> (rd_idx != '0 && rd_idx <= line_len))
    else $error("readout index out of range");

  // After the final byte is taken, the block takes input again.
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_line) |=> !in_stall)
    else $error("block did not return to idle after a line");

  // A raw byte is offered on the next cycle.
  a_raw_pass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && raw_mode && !cfg_write) |=>
      (out_valid && last_of_line && !empty_line && out_byte == $past(in_byte)))
    else $error("raw byte not passed through");

endmodule

`default_nettype wire

[tb/console_line_editor_unit_test.sv]
module console_line_editor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_TICKS = 4;

  // One byte of a completed line as the block should return it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_line;
  logic       empty_line;

  console_line_editor_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_line (last_of_line),
    .empty_line   (empty_line)
  );

  // Keys waiting to be sent, and line bytes the block still owes us.
  logic [7:0]   key_queue[$];
  line_result_t line_out_queue[$];

  // Shadow copy of the editor state.
  logic [7:0] held_line [LINE_DEPTH];
  int         held_count = 0;
  bit         raw_mode_model = 1'b0;

  int mismatch_count = 0;
  int queued_total = 0;
  int cycle_count = 0;
  bit key_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one keyboard byte to the shadow editor and queue the line bytes it releases.
  task automatic edit_key(input logic [7:0] key);
    bit ends_line;
    int n;
    ends_line = 1'b0;
    if (raw_mode_model) begin
      line_out_queue.push_back('{data: key, last: 1'b1, empty: 1'b0});
    end else begin
      if (held_count >= LINE_DEPTH) held_count = 0;
      if (key == KEY_BACKSPACE) begin
        if (held_count > 0) held_count--;
      end else if (key == KEY_KILL) begin
        held_count = 0;
      end else begin
        ends_line = (key == KEY_NEWLINE) || (key == KEY_EOF);
        held_line[held_count] = key;
        held_count++;
      end
      if (ends_line || held_count == LINE_DEPTH) begin
        // The control-D that ends a line is dropped from it.
        if (key == KEY_EOF) held_count--;
        if (held_count == 0) begin
          line_out_queue.push_back('{data: 8'h00, last: 1'b1, empty: 1'b1});
        end else begin
          for (n = 0; n < held_count; n++) begin
            line_out_queue.push_back('{data: held_line[n], last: (n == held_count - 1),
                                       empty: 1'b0});
          end
        end
        held_count = 0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Accepted requests feed the shadow editor; returned bytes are checked in order.
  always @(posedge clk) begin
    line_result_t want;
    key_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      key_queue.delete(0);
      edit_key(in_byte);
    end
    if (!rst && out_valid && !out_stall) begin
      if (line_out_queue.size() == 0) begin
        $display("%0t: no byte expected, got out_byte %h last_of_line %b empty_line %b",
                 $time, out_byte, last_of_line, empty_line);
        mismatch_count++;
      end else begin
        want = line_out_queue.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("last_of_line", 8'(want.last), 8'(last_of_line));
        check_field("empty_line", 8'(want.empty), 8'(empty_line));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sender: offers the next key unless idling; a stalled request holds its byte.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || key_taken) begin
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 63) == 0) send_calm = $urandom_range(8, 40);
      if (key_queue.size() != 0 &&
          (send_calm > 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
        in_valid <= 1'b1;
        in_byte  <= key_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, calm stretches, and a long hold on request.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (recv_calm > 0) recv_calm--;
    else if ($urandom_range(0, 63) == 0) recv_calm = $urandom_range(8, 40);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_calm == 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic queue_key(input logic [7:0] key);
    key_queue.push_back(key);
    queued_total++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = $urandom_range(0, 255);
    while (c == KEY_BACKSPACE || c == KEY_NEWLINE || c == KEY_KILL || c == KEY_EOF) begin
      c = $urandom_range(0, 255);
    end
    return c;
  endfunction

  // Line text with occasional backspace and kill when editing is enabled.
  task automatic queue_content(input int count, input bit with_edits);
    int i;
    int roll;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (with_edits && roll < 6) queue_key(KEY_BACKSPACE);
      else if (with_edits && roll == 6) queue_key(KEY_KILL);
      else queue_key(plain_char());
    end
  endtask

  task automatic queue_noise(input int count);
    int i;
    for (i = 0; i < count; i++) queue_key($urandom_range(0, 255));
  endtask

  // Mostly well-formed lines of random text, some noise in between.
  task automatic queue_mix(input int count);
    int first;
    int pick;
    first = queued_total;
    while (queued_total - first < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_noise($urandom_range(1, 6));
      end else begin
        queue_content((pick < 8) ? $urandom_range(0, 8) : $urandom_range(9, 40), 1'b1);
        queue_key(($urandom_range(0, 3) == 0) ? KEY_EOF : KEY_NEWLINE);
      end
    end
  endtask

  // Wait until every key is taken and every line byte has come back.
  task automatic wait_for_drain(input int extra);
    do @(negedge clk); while (key_queue.size() != 0 || line_out_queue.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_raw_mode(input bit raw);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= raw;
    @(negedge clk);
    cfg_write <= 1'b0;
    raw_mode_model = raw;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_raw_mode(1'b0);

    // Directed: short lines, end of file, edits on empty and partial lines, extremes.
    @(posedge clk);
    queue_key(8'h61); queue_key(8'h62); queue_key(KEY_NEWLINE);
    queue_key(KEY_EOF);
    queue_key(KEY_BACKSPACE); queue_key(8'h00); queue_key(8'hFF);
    queue_key(KEY_BACKSPACE); queue_key(8'h80); queue_key(KEY_NEWLINE);
    queue_key(8'h7F); queue_key(8'h55); queue_key(KEY_KILL);
    queue_key(8'hAA); queue_key(KEY_EOF);
    // A partial line must survive a trip through raw mode.
    queue_key(8'h01); queue_key(8'hFE);
    wait_for_drain(SETTLE_TICKS);
    set_raw_mode(1'b1);
    @(posedge clk);
    queue_key(KEY_BACKSPACE); queue_key(KEY_KILL); queue_key(KEY_EOF);
    queue_key(KEY_NEWLINE); queue_key(8'h00); queue_key(8'hFF);
    wait_for_drain(SETTLE_TICKS);
    set_raw_mode(1'b0);
    @(posedge clk);
    queue_key(8'h3C); queue_key(KEY_NEWLINE);
    wait_for_drain(SETTLE_TICKS);

    // Sender rarely idle, receiver mostly stalled: a line that fills the store, then mixed lines.
    send_idle_pct = 23;
    recv_idle_pct = 86;
    @(posedge clk);
    queue_key(KEY_KILL);
    queue_content(LINE_DEPTH, 1'b0);
    queue_mix(10);
    wait_for_drain(SETTLE_TICKS);
    set_raw_mode(1'b1);
    @(posedge clk);
    queue_noise(12);
    wait_for_drain(SETTLE_TICKS);
    set_raw_mode(1'b0);

    // Sender mostly idle, receiver rarely stalled: control-D into the last free slot.
    send_idle_pct = 86;
    recv_idle_pct = 23;
    @(posedge clk);
    queue_key(KEY_KILL);
    queue_content(LINE_DEPTH - 1, 1'b0);
    queue_key(KEY_EOF);
    queue_mix(10);
    queue_content(3, 1'b0);
    wait_for_drain(SETTLE_TICKS);
    set_raw_mode(1'b1);
    @(posedge clk);
    queue_noise(6);
    wait_for_drain(SETTLE_TICKS);
    set_raw_mode(1'b0);

    // Full speed, with the receiver holding off while lines keep arriving.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    queue_mix(25);
    hold_req++;
    wait_for_drain(SETTLE_TICKS);
    @(posedge clk);
    queue_mix(10);
    queue_key(KEY_NEWLINE);
    wait_for_drain(LINE_DEPTH + SETTLE_TICKS);

    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
